[rtl/rlbd_pkg.sv]
package rlbd_pkg;

    localparam int NUM_RANGES = 4;
    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int RANGE_W    = 2 * SAMPLE_W;
    localparam int USED_W     = 3;
    localparam int BTN_W      = 3;
    localparam int IDX_W      = 2;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;

    // button code one past the last range means "no button"
    localparam logic [BTN_W-1:0] BTN_NONE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTONS_USED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd6;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2
    } event_kind_t;

    typedef struct packed {
        event_kind_t           kind;
        logic [IDX_W-1:0]      idx;
    } event_t;

    typedef struct packed {
        logic [NUM_RANGES-1:0][RANGE_W-1:0] ranges;
        logic [SAMPLE_W-1:0]                adc_max;
        logic [USED_W-1:0]                  buttons_used;
        logic [CNT_W-1:0]                   long_press_scans;
    } cfg_t;

endpackage

[rtl/resistor_ladder_button_decoder.sv]
// Channel   | Direction | Fields (lowest bit up)
// s_axis    | in        | tdata: sample_a, sample_b, sample_c, sample_d (10 bits each)
// m_axis    | out       | tdata: button_index[1:0], zero pad; tuser: event_kind[1:0]
// cfg       | in        | cfg_we / cfg_index / cfg_data, written on the clock edge
//
// One scan per cycle sustained while the output is not stalled. A scan is
// caught in the input register; once the output register is free or drained,
// the sample sum, range compares and debounce update load the result register.
// Zero or one transaction out per scan.
// Reset (rst_n, async low) restores register defaults and the debounce state.
// While a result waits (m_tvalid high, m_tready low) the input stage holds,
// whether or not the waiting scan would make a result.
module resistor_ladder_button_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample_a, sample_b, sample_c, sample_d
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // button_index[1:0], zeros[7:2]
    output logic [1:0]  m_tuser,   // event_kind[1:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    rlbd_pkg::cfg_t                  cfg_reg;
    logic                            in_valid_reg, in_valid_next;
    logic [39:0]                     in_data_reg;
    logic                            in_accept;
    logic                            proc;
    logic [rlbd_pkg::BTN_W-1:0]      btn;
    rlbd_pkg::event_t                ev;

    assign proc          = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready      = !in_valid_reg || proc;
    assign in_accept     = s_tvalid && s_tready;
    assign in_valid_next = in_accept ? 1'b1 : (proc ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ranges           <= '0;
            cfg_reg.adc_max          <= 10'd1023;
            cfg_reg.buttons_used     <= 3'd4;
            cfg_reg.long_press_scans <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlbd_pkg::REG_RANGE0:       cfg_reg.ranges[0] <= cfg_data;
                rlbd_pkg::REG_RANGE1:       cfg_reg.ranges[1] <= cfg_data;
                rlbd_pkg::REG_RANGE2:       cfg_reg.ranges[2] <= cfg_data;
                rlbd_pkg::REG_RANGE3:       cfg_reg.ranges[3] <= cfg_data;
                rlbd_pkg::REG_ADC_MAX:      cfg_reg.adc_max <= cfg_data[9:0];
                rlbd_pkg::REG_BUTTONS_USED: cfg_reg.buttons_used <= cfg_data[2:0];
                rlbd_pkg::REG_LONG_PRESS:   cfg_reg.long_press_scans <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    rlbd_classify u_classify (
        .sample_a (in_data_reg[9:0]),
        .sample_b (in_data_reg[19:10]),
        .sample_c (in_data_reg[29:20]),
        .sample_d (in_data_reg[39:30]),
        .cfg      (cfg_reg),
        .btn      (btn)
    );

    rlbd_tracker u_tracker (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (proc),
        .btn              (btn),
        .long_press_scans (cfg_reg.long_press_scans),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_event        (ev)
    );

    assign m_tdata = {6'b0, ev.idx};
    assign m_tuser = ev.kind;

endmodule

[rtl/rlbd_classify.sv]
module rlbd_classify (
    input  logic [rlbd_pkg::SAMPLE_W-1:0] sample_a,
    input  logic [rlbd_pkg::SAMPLE_W-1:0] sample_b,
    input  logic [rlbd_pkg::SAMPLE_W-1:0] sample_c,
    input  logic [rlbd_pkg::SAMPLE_W-1:0] sample_d,
    input  rlbd_pkg::cfg_t                cfg,
    output logic [rlbd_pkg::BTN_W-1:0]    btn
);

    logic [rlbd_pkg::SUM_W-1:0]      sum;
    logic [rlbd_pkg::SAMPLE_W-1:0]   avg;
    logic [rlbd_pkg::NUM_RANGES-1:0] hit;

    assign sum = rlbd_pkg::SUM_W'(sample_a) + rlbd_pkg::SUM_W'(sample_b)
               + rlbd_pkg::SUM_W'(sample_c) + rlbd_pkg::SUM_W'(sample_d);
    assign avg = sum[rlbd_pkg::SUM_W-1:2];

    always_comb
    begin
        for (int i = 0; i < rlbd_pkg::NUM_RANGES; i++)
        begin
            hit[i] = (rlbd_pkg::USED_W'(i) < cfg.buttons_used)
                  && (avg > cfg.ranges[i][rlbd_pkg::SAMPLE_W-1:0])
                  && (avg < cfg.ranges[i][rlbd_pkg::RANGE_W-1:rlbd_pkg::SAMPLE_W]);
        end
    end

    // lowest index wins on overlap
    always_comb
    begin
        btn = rlbd_pkg::BTN_NONE;
        if (avg <= cfg.adc_max)
        begin
            for (int i = rlbd_pkg::NUM_RANGES - 1; i >= 0; i--)
            begin
                if (hit[i])
                begin
                    btn = rlbd_pkg::BTN_W'(i);
                end
            end
        end
    end

endmodule

[rtl/rlbd_tracker.sv]
module rlbd_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [rlbd_pkg::BTN_W-1:0]  btn,
    input  logic [rlbd_pkg::CNT_W-1:0]  long_press_scans,
    input  logic                        out_ready,
    output logic                        out_valid,
    output rlbd_pkg::event_t            out_event
);

    logic                        phase_reg, phase_next;
    logic [rlbd_pkg::BTN_W-1:0]  cand_reg, cand_next;
    logic [rlbd_pkg::BTN_W-1:0]  acc_reg, acc_next;
    logic                        long_fired_reg, long_fired_next;
    logic [rlbd_pkg::CNT_W-1:0]  scans_reg, scans_next;
    logic                        out_valid_reg, out_valid_next;
    rlbd_pkg::event_t            out_event_reg, out_event_next;

    logic [rlbd_pkg::CNT_W-1:0]  scans_inc;
    logic                        emit;
    rlbd_pkg::event_t            ev;

    assign scans_inc = (scans_reg == {rlbd_pkg::CNT_W{1'b1}})
                     ? scans_reg : scans_reg + rlbd_pkg::CNT_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        cand_next       = cand_reg;
        acc_next        = acc_reg;
        long_fired_next = long_fired_reg;
        scans_next      = scans_reg;
        emit            = 1'b0;
        ev.kind         = rlbd_pkg::EV_PRESS;
        ev.idx          = btn[rlbd_pkg::IDX_W-1:0];
        if (step)
        begin
            scans_next = scans_inc;
            if (!phase_reg && btn != acc_reg)
            begin
                cand_next  = btn;
                phase_next = 1'b1;
            end
            else if (phase_reg)
            begin
                phase_next = 1'b0;
                if (btn == cand_reg)
                begin
                    acc_next = btn;
                    if (btn == rlbd_pkg::BTN_NONE)
                    begin
                        emit    = !long_fired_reg && (acc_reg != rlbd_pkg::BTN_NONE);
                        ev.kind = rlbd_pkg::EV_RELEASE;
                        ev.idx  = acc_reg[rlbd_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        emit            = 1'b1;
                        scans_next      = '0;
                        long_fired_next = 1'b0;
                    end
                end
            end
            else if (btn != rlbd_pkg::BTN_NONE && scans_inc >= long_press_scans)
            begin
                // held button: periodic long-press, counter restarts
                emit            = 1'b1;
                scans_next      = '0;
                long_fired_next = 1'b1;
                ev.kind         = rlbd_pkg::EV_LONG;
                ev.idx          = acc_reg[rlbd_pkg::IDX_W-1:0];
            end
        end
    end

    // step is only given while the output register is free or being drained
    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_event_next = emit ? ev : out_event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            cand_reg       <= rlbd_pkg::BTN_NONE;
            acc_reg        <= rlbd_pkg::BTN_NONE;
            long_fired_reg <= 1'b0;
            scans_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cand_reg       <= cand_next;
            acc_reg        <= acc_next;
            long_fired_reg <= long_fired_next;
            scans_reg      <= scans_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_event_reg <= out_event_next;
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;

endmodule

[rtl/rlbd_checker.sv]
module rlbd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [1:0]  m_tuser
);

    logic       out_xfer;
    logic       held_reg;
    logic [1:0] held_idx_reg;
    logic       long_seen_reg;

    assign out_xfer = m_tvalid && m_tready;

    // shadow of which button is down, as seen from the output events
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            held_idx_reg  <= 2'd0;
            long_seen_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            if (m_tuser == rlbd_pkg::EV_PRESS)
            begin
                held_reg      <= 1'b1;
                held_idx_reg  <= m_tdata[1:0];
                long_seen_reg <= 1'b0;
            end
            else if (m_tuser == rlbd_pkg::EV_RELEASE)
            begin
                held_reg <= 1'b0;
            end
            else
            begin
                long_seen_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:2] == 6'd0)
        else $error("tdata pad bits not zero");

    a_release_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && m_tuser == rlbd_pkg::EV_RELEASE
        |-> held_reg && !long_seen_reg && m_tdata[1:0] == held_idx_reg)
        else $error("release without matching short press");

    a_long_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && m_tuser == rlbd_pkg::EV_LONG
        |-> held_reg && m_tdata[1:0] == held_idx_reg)
        else $error("long press on a button not held");

endmodule

bind resistor_ladder_button_decoder rlbd_checker u_rlbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/tb.sv]
module tb;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_TAIL   = 4;    // two-stage pipe plus margin
    localparam int HOLD_CYCLES  = 80;
    localparam logic [rlbd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [2:0] {
        OP_SCAN,
        OP_CFG,
        OP_DRAIN,
        OP_HOLD,
        OP_QUIET
    } op_kind_t;

    typedef struct packed {
        op_kind_t                        kind;
        logic [39:0]                     samples;
        logic [rlbd_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [rlbd_pkg::RANGE_W-1:0]    reg_val;
    } stim_op_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    resistor_ladder_button_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stim_op_t         pending_ops[$];
    rlbd_pkg::event_t expected_events[$];

    // decoder mirror: configuration
    logic [rlbd_pkg::RANGE_W-1:0]  cur_rng [rlbd_pkg::NUM_RANGES] = '{default: '0};
    logic [rlbd_pkg::SAMPLE_W-1:0] cur_adc_max = 10'd1023;
    logic [rlbd_pkg::USED_W-1:0]   cur_used = 3'd4;
    logic [rlbd_pkg::CNT_W-1:0]    cur_long = 16'd100;

    // decoder mirror: debounce state
    logic                       confirm_ph = 1'b0;
    logic [rlbd_pkg::BTN_W-1:0] cand_btn = rlbd_pkg::BTN_NONE;
    logic [rlbd_pkg::BTN_W-1:0] acc_btn = rlbd_pkg::BTN_NONE;
    logic                       long_done = 1'b0;
    logic [rlbd_pkg::CNT_W-1:0] held_scans = '0;

    // stimulus planning copy of the ranges
    logic [rlbd_pkg::RANGE_W-1:0] plan_rng [rlbd_pkg::NUM_RANGES] = '{default: '0};
    int plan_long = 100;

    int  mismatches = 0;
    int  cycle_count = 0;
    int  scans_sent = 0;
    int  cfg_writes = 0;
    int  press_seen = 0;
    int  release_seen = 0;
    int  long_seen = 0;
    int  hold_reqs = 0;
    int  holds_served = 0;
    bit  quiet = 1'b0;
    bit  scan_taken = 1'b0;
    bit  all_sent = 1'b0;

    function automatic logic [rlbd_pkg::BTN_W-1:0] match_button(
        input logic [rlbd_pkg::SAMPLE_W-1:0] avg);
        int n;
        logic [rlbd_pkg::BTN_W-1:0] hit;
        n = (cur_used > rlbd_pkg::NUM_RANGES) ? rlbd_pkg::NUM_RANGES : int'(cur_used);
        hit = rlbd_pkg::BTN_NONE;
        if (avg <= cur_adc_max)
        begin
            // walk downward so the lowest matching index is kept
            for (int i = n - 1; i >= 0; i--)
                if (avg > cur_rng[i][9:0] && avg < cur_rng[i][19:10])
                    hit = rlbd_pkg::BTN_W'(i);
        end
        return hit;
    endfunction

    task automatic push_event(input rlbd_pkg::event_kind_t kind,
                              input logic [rlbd_pkg::BTN_W-1:0] btn);
        rlbd_pkg::event_t ev;
        ev.kind = kind;
        ev.idx  = btn[rlbd_pkg::IDX_W-1:0];
        expected_events.push_back(ev);
    endtask

    task automatic decode_scan(input logic [39:0] d);
        logic [rlbd_pkg::SUM_W-1:0] sum;
        logic [rlbd_pkg::BTN_W-1:0] btn;
        sum = rlbd_pkg::SUM_W'(d[9:0]) + rlbd_pkg::SUM_W'(d[19:10])
            + rlbd_pkg::SUM_W'(d[29:20]) + rlbd_pkg::SUM_W'(d[39:30]);
        btn = match_button(sum[rlbd_pkg::SUM_W-1:2]);
        if (held_scans != '1)
            held_scans++;
        if (!confirm_ph && btn != acc_btn)
        begin
            cand_btn   = btn;
            confirm_ph = 1'b1;
        end
        else if (confirm_ph)
        begin
            confirm_ph = 1'b0;
            if (btn == cand_btn)
            begin
                if (btn == rlbd_pkg::BTN_NONE)
                begin
                    if (!long_done && acc_btn != rlbd_pkg::BTN_NONE)
                        push_event(rlbd_pkg::EV_RELEASE, acc_btn);
                end
                else
                begin
                    held_scans = '0;
                    long_done  = 1'b0;
                    push_event(rlbd_pkg::EV_PRESS, btn);
                end
                acc_btn = btn;
            end
        end
        else if (btn != rlbd_pkg::BTN_NONE && held_scans >= cur_long)
        begin
            held_scans = '0;
            long_done  = 1'b1;
            push_event(rlbd_pkg::EV_LONG, acc_btn);
        end
    endtask

    task automatic apply_cfg(input logic [rlbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [19:0] val);
        case (idx)
            rlbd_pkg::REG_RANGE0, rlbd_pkg::REG_RANGE1,
            rlbd_pkg::REG_RANGE2, rlbd_pkg::REG_RANGE3:
                cur_rng[idx[1:0]] = val;
            rlbd_pkg::REG_ADC_MAX:      cur_adc_max = val[rlbd_pkg::SAMPLE_W-1:0];
            rlbd_pkg::REG_BUTTONS_USED: cur_used = val[rlbd_pkg::USED_W-1:0];
            rlbd_pkg::REG_LONG_PRESS:   cur_long = val[rlbd_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // ---------------- stimulus planning ----------------

    task automatic add_op(input op_kind_t kind);
        stim_op_t op;
        op = '0;
        op.kind = kind;
        pending_ops.push_back(op);
    endtask

    task automatic add_cfg(input logic [rlbd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [19:0] val);
        stim_op_t op;
        op = '0;
        op.kind    = OP_CFG;
        op.reg_idx = idx;
        op.reg_val = val;
        if (idx <= rlbd_pkg::REG_RANGE3)
            plan_rng[idx[1:0]] = val;
        else if (idx == rlbd_pkg::REG_LONG_PRESS)
            plan_long = int'(val[rlbd_pkg::CNT_W-1:0]);
        pending_ops.push_back(op);
    endtask

    task automatic add_scan(input logic [39:0] raw);
        stim_op_t op;
        op = '0;
        op.kind    = OP_SCAN;
        op.samples = raw;
        pending_ops.push_back(op);
    endtask

    // split a sample sum into four random in-range samples
    task automatic add_sum(input int total);
        int left;
        int lo_v;
        int hi_v;
        logic [9:0] smp [4];
        left = total;
        for (int k = 0; k < 3; k++)
        begin
            lo_v = left - 1023 * (3 - k);
            if (lo_v < 0)
                lo_v = 0;
            hi_v = (left > 1023) ? 1023 : left;
            smp[k] = 10'($urandom_range(hi_v, lo_v));
            left -= int'(smp[k]);
        end
        smp[3] = 10'(left);
        add_scan({smp[3], smp[2], smp[1], smp[0]});
    endtask

    // four full-scale samples sum to 4092 at most
    task automatic add_level(input int avg);
        int total;
        total = avg * 4 + int'($urandom_range(0, 3));
        add_sum((total > 4092) ? 4092 : total);
    endtask

    function automatic logic [19:0] range_word(input int hi, input int lo);
        return {10'(hi), 10'(lo)};
    endfunction

    // an average aimed at one button; for index NUM_RANGES or an empty range, zero or any level
    function automatic int pick_level(input int which);
        int lo;
        int hi;
        if (which < rlbd_pkg::NUM_RANGES)
        begin
            lo = int'(plan_rng[which][9:0]);
            hi = int'(plan_rng[which][19:10]);
            if (hi > lo + 1)
                return int'($urandom_range(hi - 1, lo + 1));
        end
        // an average of zero can never sit strictly above a low bound
        if ($urandom_range(0, 1) == 0)
            return 0;
        return int'($urandom_range(0, 1023));
    endfunction

    task automatic add_random(input int count);
        int made;
        int which;
        int hold;
        int hold_max;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    add_level(int'($urandom_range(0, 1023)));
                    made++;
                end
                8, 9:
                    begin
                        add_scan(40'({$urandom(), $urandom()}));
                        made++;
                    end
                default:
                begin
                    // a held reading, jittered inside the same target
                    which = int'($urandom_range(0, rlbd_pkg::NUM_RANGES));
                    hold_max = (plan_long < 6) ? 2 * plan_long + 3 : 14;
                    hold = int'($urandom_range(1, hold_max));
                    for (int k = 0; k < hold; k++)
                        add_level(pick_level(which));
                    made += hold;
                end
            endcase
        end
    endtask

    task automatic ladder_cfg(input int used, input int adc_lim, input int long_lim);
        add_cfg(rlbd_pkg::REG_RANGE0, range_word(200, 100));
        add_cfg(rlbd_pkg::REG_RANGE1, range_word(450, 300));
        add_cfg(rlbd_pkg::REG_RANGE2, range_word(700, 500));
        add_cfg(rlbd_pkg::REG_RANGE3, range_word(900, 750));
        add_cfg(rlbd_pkg::REG_ADC_MAX, 20'(adc_lim));
        add_cfg(rlbd_pkg::REG_BUTTONS_USED, 20'(used));
        add_cfg(rlbd_pkg::REG_LONG_PRESS, 20'(long_lim));
    endtask

    task automatic plan_run();
        int lo;
        // directed: extremes, press, long press, silent release, direct change,
        // debounce glitch, short release, exclusive bounds and floor of the average
        ladder_cfg(4, 1000, 2);
        add_scan('1);
        add_scan('0);
        repeat (4) add_level(150);
        repeat (2) add_level(0);
        repeat (2) add_level(350);
        repeat (2) add_level(600);
        add_level(800);
        repeat (2) add_level(600);
        repeat (2) add_level(800);
        repeat (2) add_sum(3);
        add_sum(400);
        add_sum(800);
        add_sum(404);
        add_sum(407);
        repeat (2) add_level(0);

        // ladder, with a long output stall in the middle
        add_op(OP_DRAIN);
        ladder_cfg(4, 1000, 3);
        add_random(100);
        add_op(OP_HOLD);
        for (int k = 0; k < 40; k++)
            add_level(pick_level(k % rlbd_pkg::NUM_RANGES));
        add_random(60);

        // random, possibly overlapping ranges
        add_op(OP_DRAIN);
        for (int i = 0; i < rlbd_pkg::NUM_RANGES; i++)
        begin
            lo = int'($urandom_range(0, 900));
            add_cfg(rlbd_pkg::CFG_IDX_W'(i),
                range_word(lo + int'($urandom_range(0, 300)) > 1023 ?
                1023 : lo + int'($urandom_range(0, 300)), lo));
        end
        add_cfg(rlbd_pkg::REG_ADC_MAX, 20'($urandom_range(0, 1023)));
        add_cfg(rlbd_pkg::REG_BUTTONS_USED, 20'($urandom_range(0, 7)));
        add_cfg(rlbd_pkg::REG_LONG_PRESS, 20'($urandom_range(1, 6)));
        add_cfg(REG_UNUSED, 20'($urandom()));
        add_random(150);

        // extremes: full-width range, empty ranges, zero threshold, too many buttons
        add_op(OP_DRAIN);
        add_cfg(rlbd_pkg::REG_RANGE0, range_word(1023, 0));
        add_cfg(rlbd_pkg::REG_RANGE1, 20'hFFFFF);
        add_cfg(rlbd_pkg::REG_RANGE2, range_word(512, 511));
        add_cfg(rlbd_pkg::REG_RANGE3, range_word(600, 400));
        add_cfg(rlbd_pkg::REG_ADC_MAX, 20'd1023);
        add_cfg(rlbd_pkg::REG_BUTTONS_USED, 20'd7);
        add_cfg(rlbd_pkg::REG_LONG_PRESS, 20'd0);
        add_random(150);

        // nothing can match
        add_op(OP_DRAIN);
        add_cfg(rlbd_pkg::REG_ADC_MAX, 20'd0);
        add_cfg(rlbd_pkg::REG_BUTTONS_USED, 20'd0);
        add_random(30);

        // one button, top threshold
        add_op(OP_DRAIN);
        ladder_cfg(1, 511, 65535);
        add_random(150);

        // threshold of one, two buttons
        add_op(OP_DRAIN);
        ladder_cfg(2, 1023, 1);
        add_random(150);

        // closing stretch without idling
        add_op(OP_DRAIN);
        ladder_cfg(4, 950, 4);
        add_op(OP_QUIET);
        add_random(150);
        add_op(OP_DRAIN);
    endtask

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        stim_op_t    op;
        logic        nxt_valid;
        logic [39:0] nxt_data;
        logic        nxt_we;
        logic [2:0]  nxt_idx;
        logic [19:0] nxt_val;
        static int   wait_left = 0;
        static bit   draining = 1'b0;
        if (rst_n)
        begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            nxt_we    = 1'b0;
            nxt_idx   = cfg_index;
            nxt_val   = cfg_data;
            if (scan_taken)
            begin
                nxt_valid  = 1'b0;
                scan_taken = 1'b0;
                if (!quiet && $urandom_range(0, 5) == 0)
                    wait_left = int'($urandom_range(1, 18));
            end
            if (!nxt_valid)
            begin
                if (wait_left > 0)
                    wait_left--;
                else if (draining)
                begin
                    if (expected_events.size() == 0)
                    begin
                        draining  = 1'b0;
                        wait_left = DRAIN_TAIL;
                    end
                end
                else if (pending_ops.size() > 0)
                begin
                    op = pending_ops.pop_front();
                    case (op.kind)
                        OP_SCAN:
                        begin
                            nxt_valid = 1'b1;
                            nxt_data  = op.samples;
                        end
                        OP_CFG:
                        begin
                            nxt_we  = 1'b1;
                            nxt_idx = op.reg_idx;
                            nxt_val = op.reg_val;
                        end
                        OP_DRAIN: draining = 1'b1;
                        OP_HOLD:  hold_reqs++;
                        OP_QUIET: quiet = 1'b1;
                        default: ;
                    endcase
                end
                else
                    all_sent = 1'b1;
            end
            s_tvalid  <= nxt_valid;
            s_tdata   <= nxt_data;
            cfg_we    <= nxt_we;
            cfg_index <= nxt_idx;
            cfg_data  <= nxt_val;
        end
    end

    // ---------------- output back-pressure ----------------

    always @(negedge clk)
    begin
        logic      nxt_ready;
        static int stall_left = 0;
        static int hold_left = 0;
        if (rst_n)
        begin
            if (hold_reqs != holds_served)
            begin
                holds_served = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (quiet)
                nxt_ready = 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = int'($urandom_range(0, 17));
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            m_tready <= nxt_ready;
        end
    end

    // ---------------- monitor and checker ----------------

    always @(posedge clk)
    begin
        rlbd_pkg::event_t want;
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_events.size());
            $display("TB_ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                case (m_tuser)
                    rlbd_pkg::EV_PRESS:   press_seen++;
                    rlbd_pkg::EV_RELEASE: release_seen++;
                    rlbd_pkg::EV_LONG:    long_seen++;
                    default: ;
                endcase
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event: kind %0d button %0d",
                                 m_tuser, m_tdata[1:0]);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tuser !== want.kind || m_tdata[1:0] !== want.idx
                        || m_tdata[7:2] !== '0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"event mismatch: expected kind %0d button %0d, ",
                                      "got kind %0d button %0d pad %h"},
                                     want.kind, want.idx, m_tuser, m_tdata[1:0],
                                     m_tdata[7:2]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_scan(s_tdata);
                scans_sent++;
                scan_taken = 1'b1;
            end
            if (cfg_we)
            begin
                apply_cfg(cfg_index, cfg_data);
                cfg_writes++;
            end
        end
    end

    initial
    begin
        plan_run();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (all_sent);
        repeat (8) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $display("%0d expected events never arrived", expected_events.size());
            mismatches += expected_events.size();
        end
        $display("%0d scans and %0d register writes over 8 settings",
                 scans_sent, cfg_writes);
        $display("events checked: %0d press, %0d release, %0d long",
                 press_seen, release_seen, long_seen);
        $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
